/* rtl/core/rsls_pkg.sv */
// Package for the RGB status LED sequencer core.
// Mode encodings, one-hot mode states, register indexes and fixed constants.
// No dependencies.
package rsls_pkg;

  localparam int unsigned DutyW   = 8;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned ToggleW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [ModeW-1:0] MODE_CODE_CONNECTING = 3'd0;
  localparam logic [ModeW-1:0] MODE_CODE_OFFLINE    = 3'd1;
  localparam logic [ModeW-1:0] MODE_CODE_CONNECTED  = 3'd2;
  localparam logic [ModeW-1:0] MODE_CODE_LOCK       = 3'd3;
  localparam logic [ModeW-1:0] MODE_CODE_UNLOCK     = 3'd4;
  localparam logic [ModeW-1:0] MODE_CODE_SUCCESS    = 3'd5;
  localparam logic [ModeW-1:0] MODE_CODE_FAIL       = 3'd6;

  localparam logic [CfgIdxW-1:0] CFG_CONNECT_HALF = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FLASH_HALF   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TIME    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FLASH_TOGGLES = 2'd3;

  localparam logic [TimeW-1:0]   CONNECT_HALF_RST  = 16'd300;
  localparam logic [TimeW-1:0]   FLASH_HALF_RST    = 16'd200;
  localparam logic [TimeW-1:0]   HOLD_TIME_RST     = 16'd1000;
  localparam logic [ToggleW-1:0] FLASH_TOGGLES_RST = 4'd6;

  localparam logic [DutyW-1:0] DUTY_FULL = 8'd255;
  localparam logic [DutyW-1:0] DUTY_OFF  = 8'd0;
  localparam logic [TimeW-1:0] TIME_MAX  = 16'hFFFF;

  // Q14/Q15 sine polynomial coefficients
  localparam logic [11:0] SIN_C    = 12'd2320;
  localparam logic [14:0] SIN_B    = 15'd21024;
  localparam logic [15:0] SIN_A    = 16'd51472;
  localparam logic [14:0] QUARTER  = 15'd16384;
  localparam logic [15:0] S_CLAMP  = 16'd32768;
  localparam logic [16:0] MIDSCALE = 17'd32768;

  typedef enum logic [6:0] {
    MODE_CONNECTING = 7'b0000001,
    MODE_OFFLINE    = 7'b0000010,
    MODE_CONNECTED  = 7'b0000100,
    MODE_LOCK       = 7'b0001000,
    MODE_UNLOCK     = 7'b0010000,
    MODE_SUCCESS    = 7'b0100000,
    MODE_FAIL       = 7'b1000000
  } mode_e;

  function automatic logic [ModeW-1:0] mode_encode(mode_e m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_CONNECTING: c = MODE_CODE_CONNECTING;
      MODE_OFFLINE:    c = MODE_CODE_OFFLINE;
      MODE_CONNECTED:  c = MODE_CODE_CONNECTED;
      MODE_LOCK:       c = MODE_CODE_LOCK;
      MODE_UNLOCK:     c = MODE_CODE_UNLOCK;
      MODE_SUCCESS:    c = MODE_CODE_SUCCESS;
      MODE_FAIL:       c = MODE_CODE_FAIL;
      default:         c = MODE_CODE_CONNECTING;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/rgb_status_led_sequencer_core.sv */
// RGB status LED sequencer core: mode control, blink timing and rainbow lanes.
// Depends on rsls_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries func_i and new_mode_i. A tick
//   (func_i = 0) advances time by 1 ms and yields one result transfer on the
//   output channel (out_valid_o/out_ready_i): three PWM duties and mode_now_o.
//   A set-mode command (func_i = 1) yields no result.
//   Config channel (cfg_valid_i/cfg_ready_o) writes cfg_data_i to the register
//   at cfg_index_i; it is always ready.
//   Latency: a tick's result is valid the cycle after its transfer.
//   Throughput: one input transfer per cycle unless filling or stalled; the
//   output register is refilled in the same cycle it is drained.
//   Each of the three rainbow lanes is a four-stage multiplier pipeline that
//   runs one phase ahead per stage and advances once per tick or fill step.
//   Reset: registers take their reset values; in_ready_o stays low while the
//   rainbow pipelines fill.
//   Stall: while a result waits and out_ready_i is low, in_ready_o is low and
//   the result holds.
module rgb_status_led_sequencer_core #(
  parameter int unsigned RAINBOW_PERIOD_MS = 4000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [rsls_pkg::ModeW-1:0]      new_mode_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rsls_pkg::DutyW-1:0]      red_duty_o,
  output logic [rsls_pkg::DutyW-1:0]      green_duty_o,
  output logic [rsls_pkg::DutyW-1:0]      blue_duty_o,
  output logic [rsls_pkg::ModeW-1:0]      mode_now_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rsls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rsls_pkg::CfgW-1:0]       cfg_data_i
);
  import rsls_pkg::*;

  localparam int unsigned P         = RAINBOW_PERIOD_MS;
  localparam int unsigned StepQ     = 65536 / P;
  localparam int unsigned StepR     = 65536 % P;
  localparam int unsigned OffG      = (P + 1) / 3;
  localparam int unsigned OffB      = (2 * P + 1) / 3;
  localparam int unsigned FillStages = 4;
  localparam int unsigned Lanes     = 3;

  // Configuration
  logic [TimeW-1:0]   connect_half_q, flash_half_q, hold_time_q;
  logic [ToggleW-1:0] flash_toggles_q;

  // Control state
  mode_e              mode_q, mode_d;
  logic               blink_q, blink_d;
  logic [ToggleW-1:0] toggle_cnt_q, toggle_cnt_d;
  logic [TimeW-1:0]   since_q, since_d;
  logic               force_q, force_d;
  logic [TimeW-1:0]   in_mode_q, in_mode_d;
  logic [DutyW-1:0]   red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic               out_valid_q, out_valid_d;
  logic [ModeW-1:0]   mode_out_q, mode_out_d;
  logic [2:0]         fill_q;

  logic               fill_busy, adv, in_xfer, tick_xfer, cmd_xfer, cmd_ok;
  logic               nm_legal;
  mode_e              nm_mode;
  logic [TimeW-1:0]   since_inc, in_mode_inc, half;
  logic               pass;
  logic [DutyW-1:0]   blink_duty;

  // Rainbow lane registers
  logic [11:0]      q_q   [Lanes];
  logic [15:0]      ang_q [Lanes];
  logic [11:0]      rem_q [Lanes];
  logic [14:0]      s1_z2_q [Lanes];
  logic [14:0]      s1_r_q  [Lanes];
  logic [1:0]       s1_qd_q [Lanes];
  logic [11:0]      s2_t1_q [Lanes];
  logic [14:0]      s2_z2_q [Lanes];
  logic [14:0]      s2_r_q  [Lanes];
  logic [1:0]       s2_qd_q [Lanes];
  logic [14:0]      s3_t2_q [Lanes];
  logic [14:0]      s3_r_q  [Lanes];
  logic [1:0]       s3_qd_q [Lanes];
  logic [DutyW-1:0] lane_duty_q [Lanes];

  assign fill_busy = (fill_q != 3'(FillStages));
  assign in_ready_o = !fill_busy && (!out_valid_q || out_ready_i);
  assign in_xfer = in_valid_i && in_ready_o;
  assign tick_xfer = in_xfer && !func_i;
  assign cmd_xfer = in_xfer && func_i;
  assign adv = fill_busy || tick_xfer;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
    end else if (fill_busy) begin
      fill_q <= fill_q + 3'd1;
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    localparam int unsigned LaneOff = (l == 0) ? 0 : ((l == 1) ? OffG : OffB);
    localparam int unsigned Q0 = (1 + LaneOff) % P;
    localparam int unsigned A0 = (Q0 * 65536) / P;
    localparam int unsigned R0 = (Q0 * 65536) % P;

    logic [12:0] rem_sum;
    logic        carry;
    logic [1:0]  quad;
    logic [14:0] r;
    logic [29:0] p1;
    logic [26:0] p2;
    logic [14:0] u;
    logic [29:0] p3;
    logic [15:0] w;
    logic [30:0] p4;
    logic [15:0] s, sc;
    logic [16:0] v;
    logic [24:0] scaled;

    assign rem_sum = {1'b0, rem_q[l]} + 13'(StepR);
    assign carry = (rem_sum >= 13'(P));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        q_q[l]   <= 12'(Q0);
        ang_q[l] <= 16'(A0);
        rem_q[l] <= 12'(R0);
      end else if (adv) begin
        if (q_q[l] == 12'(P - 1)) begin
          q_q[l]   <= 12'd0;
          ang_q[l] <= 16'd0;
          rem_q[l] <= 12'd0;
        end else begin
          q_q[l]   <= q_q[l] + 12'd1;
          ang_q[l] <= ang_q[l] + 16'(StepQ) + {15'd0, carry};
          rem_q[l] <= carry ? 12'(rem_sum - 13'(P)) : rem_sum[11:0];
        end
      end
    end

    assign quad = ang_q[l][15:14];
    assign r = quad[0] ? (QUARTER - {1'b0, ang_q[l][13:0]}) : {1'b0, ang_q[l][13:0]};
    assign p1 = r * r;
    assign p2 = SIN_C * s1_z2_q[l];
    assign u = SIN_B - {3'd0, s2_t1_q[l]};
    assign p3 = u * s2_z2_q[l];
    assign w = SIN_A - {1'b0, s3_t2_q[l]};
    assign p4 = w * s3_r_q[l];
    assign s = p4[29:14];
    assign sc = (s > S_CLAMP) ? S_CLAMP : s;
    assign v = s3_qd_q[l][1] ? (MIDSCALE - {1'b0, sc}) : (MIDSCALE + {1'b0, sc});
    assign scaled = {v, 8'd0} - {8'd0, v};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s1_z2_q[l]     <= p1[28:14];
        s1_r_q[l]      <= r;
        s1_qd_q[l]     <= quad;
        s2_t1_q[l]     <= p2[25:14];
        s2_z2_q[l]     <= s1_z2_q[l];
        s2_r_q[l]      <= s1_r_q[l];
        s2_qd_q[l]     <= s1_qd_q[l];
        s3_t2_q[l]     <= p3[28:14];
        s3_r_q[l]      <= s2_r_q[l];
        s3_qd_q[l]     <= s2_qd_q[l];
        lane_duty_q[l] <= scaled[23:16];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connect_half_q  <= CONNECT_HALF_RST;
      flash_half_q    <= FLASH_HALF_RST;
      hold_time_q     <= HOLD_TIME_RST;
      flash_toggles_q <= FLASH_TOGGLES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CONNECT_HALF:  connect_half_q  <= cfg_data_i;
        CFG_FLASH_HALF:    flash_half_q    <= cfg_data_i;
        CFG_HOLD_TIME:     hold_time_q     <= cfg_data_i;
        CFG_FLASH_TOGGLES: flash_toggles_q <= cfg_data_i[ToggleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nm_legal = 1'b1;
    case (new_mode_i)
      MODE_CODE_CONNECTING: nm_mode = MODE_CONNECTING;
      MODE_CODE_OFFLINE:    nm_mode = MODE_OFFLINE;
      MODE_CODE_CONNECTED:  nm_mode = MODE_CONNECTED;
      MODE_CODE_LOCK:       nm_mode = MODE_LOCK;
      MODE_CODE_UNLOCK:     nm_mode = MODE_UNLOCK;
      MODE_CODE_SUCCESS:    nm_mode = MODE_SUCCESS;
      MODE_CODE_FAIL:       nm_mode = MODE_FAIL;
      default: begin
        nm_mode  = MODE_CONNECTING;
        nm_legal = 1'b0;
      end
    endcase
  end

  assign cmd_ok = nm_legal && !(nm_mode == MODE_CONNECTING && mode_q == MODE_OFFLINE);
  assign since_inc = (since_q == TIME_MAX) ? since_q : since_q + 16'd1;
  assign in_mode_inc = (in_mode_q == TIME_MAX) ? in_mode_q : in_mode_q + 16'd1;
  assign half = (mode_q == MODE_CONNECTING) ? connect_half_q : flash_half_q;
  assign pass = force_q || (since_inc >= half);
  assign blink_duty = blink_q ? DUTY_OFF : DUTY_FULL;

  always_comb begin
    mode_d       = mode_q;
    blink_d      = blink_q;
    toggle_cnt_d = toggle_cnt_q;
    since_d      = since_q;
    force_d      = force_q;
    in_mode_d    = in_mode_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    mode_out_d   = mode_out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (cmd_xfer && cmd_ok) begin
      mode_d       = nm_mode;
      toggle_cnt_d = '0;
      blink_d      = 1'b0;
      since_d      = '0;
      force_d      = 1'b1;
      in_mode_d    = '0;
    end else if (tick_xfer) begin
      since_d   = since_inc;
      in_mode_d = in_mode_inc;
      case (mode_q)
        MODE_CONNECTING: begin
          if (pass) begin
            blink_d = ~blink_q;
            since_d = '0;
            force_d = 1'b0;
            red_d   = blink_duty;
            green_d = DUTY_OFF;
            blue_d  = DUTY_OFF;
          end
        end
        MODE_OFFLINE: begin
          red_d   = DUTY_FULL;
          green_d = DUTY_FULL;
          blue_d  = DUTY_OFF;
        end
        MODE_CONNECTED: begin
          red_d   = lane_duty_q[0];
          green_d = lane_duty_q[1];
          blue_d  = lane_duty_q[2];
        end
        MODE_LOCK, MODE_UNLOCK: begin
          red_d   = (mode_q == MODE_LOCK) ? DUTY_FULL : DUTY_OFF;
          green_d = (mode_q == MODE_LOCK) ? DUTY_OFF : DUTY_FULL;
          blue_d  = DUTY_OFF;
          if (in_mode_inc >= hold_time_q) begin
            mode_d = MODE_CONNECTED;
          end
        end
        MODE_SUCCESS, MODE_FAIL: begin
          if (toggle_cnt_q >= flash_toggles_q) begin
            red_d        = DUTY_OFF;
            green_d      = DUTY_OFF;
            blue_d       = DUTY_OFF;
            mode_d       = MODE_CONNECTED;
            toggle_cnt_d = '0;
            force_d      = 1'b1;
          end else if (pass) begin
            blink_d      = ~blink_q;
            since_d      = '0;
            force_d      = 1'b0;
            red_d        = (mode_q == MODE_FAIL) ? blink_duty : DUTY_OFF;
            green_d      = (mode_q == MODE_SUCCESS) ? blink_duty : DUTY_OFF;
            blue_d       = DUTY_OFF;
            toggle_cnt_d = toggle_cnt_q + 4'd1;
          end
        end
        default: ;
      endcase
      out_valid_d = 1'b1;
      mode_out_d  = mode_encode(mode_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_CONNECTING;
      blink_q      <= 1'b0;
      toggle_cnt_q <= '0;
      since_q      <= '0;
      force_q      <= 1'b1;
      in_mode_q    <= '0;
      red_q        <= DUTY_OFF;
      green_q      <= DUTY_OFF;
      blue_q       <= DUTY_OFF;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      blink_q      <= blink_d;
      toggle_cnt_q <= toggle_cnt_d;
      since_q      <= since_d;
      force_q      <= force_d;
      in_mode_q    <= in_mode_d;
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_out_q <= mode_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = red_q;
  assign green_duty_o = green_q;
  assign blue_duty_o  = blue_q;
  assign mode_now_o   = mode_out_q;

`ifndef SYNTHESIS
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_xfer |=> out_valid_o)
    else $error("tick transfer produced no result");

  a_cmd_keeps_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_xfer |=> ($stable(red_duty_o) && $stable(green_duty_o) && $stable(blue_duty_o)))
    else $error("command changed a duty");

  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy |-> !in_xfer && !out_valid_o)
    else $error("transfer during pipeline fill");

  a_mode_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mode_now_o <= MODE_CODE_FAIL))
    else $error("illegal mode code on output");
`endif

endmodule
